@@ design/set_associative_lru_cache_sim_unit_defines.svh @@
// assertion macros for the cache simulator unit checker
// no dependencies; included by the checker file only
`ifndef SET_ASSOCIATIVE_LRU_CACHE_SIM_UNIT_DEFINES_SVH
`define SET_ASSOCIATIVE_LRU_CACHE_SIM_UNIT_DEFINES_SVH

// same-cycle implication
`define SCU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scu check failed");

// next-cycle implication
`define SCU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scu check failed");

`endif

@@ design/scu_pkg.sv @@
// shared types, constants and helpers of the cache simulator unit
// no dependencies; used by the interfaces, the datapath, controller, top and checker
package scu_pkg;

  localparam int ADDR_W = 64;
  localparam int CNT_W  = 32;

  localparam logic [2:0] SET_BITS_RST    = 3'd4;
  localparam logic [5:0] OFFSET_BITS_RST = 6'd4;
  localparam logic [2:0] WAYS_RST        = 3'd1;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_STORE  = 2'd1,
    KIND_MODIFY = 2'd2,
    KIND_IFETCH = 2'd3
  } kind_e;

  // controller to datapath
  typedef struct packed {
    logic lookup;  // item accepted, read its set
    logic commit;  // resolve the lookup and write back
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_fetch;
  } ctrl_sts_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

endpackage

@@ design/scu_if.sv @@
// handshake channels of the cache simulator unit: access items in, results out
// depends on scu_pkg
interface scu_acc_if;
  import scu_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [ADDR_W-1:0] address;

  modport source (output valid, kind, address, input ready);
  modport sink   (input valid, kind, address, output ready);
endinterface

interface scu_res_if;
  import scu_pkg::*;
  logic             valid;
  logic             ready;
  logic             hit;
  logic             evicted;
  logic [CNT_W-1:0] hits_total;
  logic [CNT_W-1:0] misses_total;
  logic [CNT_W-1:0] evictions_total;

  modport source (output valid, hit, evicted, hits_total, misses_total, evictions_total,
                  input ready);
  modport sink   (input valid, hit, evicted, hits_total, misses_total, evictions_total,
                  output ready);
endinterface

@@ design/scu_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module scu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/scu_ctrl.sv @@
// controller of the cache simulator unit: accept, lookup and result handshake
// depends on scu_pkg
module scu_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  scu_pkg::ctrl_sts_t sts_i,
  output scu_pkg::ctrl_cmd_t cmd_o
);
  import scu_pkg::*;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_LOOKUP = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.lookup = accept && !sts_i.is_fetch;
    cmd_o.commit = (state_q == ST_LOOKUP) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        // fetches leave no trace, so stay put
        if (cmd_o.lookup) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (cmd_o.commit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ design/scu_dpath.sv @@
// datapath of the cache simulator unit: address split, per-way tag/rank rams,
// valid bits, hit/victim selection, recency update and saturating counters
// depends on scu_pkg and scu_ram
module scu_dpath #(
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS         = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  scu_pkg::ctrl_cmd_t         cmd_i,
  output scu_pkg::ctrl_sts_t         sts_o,
  input  logic [1:0]                 kind_i,
  input  logic [scu_pkg::ADDR_W-1:0] address_i,
  input  logic [2:0]                 set_bits_i,
  input  logic [5:0]                 offset_bits_i,
  input  logic [2:0]                 ways_i,
  output logic                       hit_o,
  output logic                       evicted_o,
  output logic [scu_pkg::CNT_W-1:0]  hits_total_o,
  output logic [scu_pkg::CNT_W-1:0]  misses_total_o,
  output logic [scu_pkg::CNT_W-1:0]  evictions_total_o
);
  import scu_pkg::*;

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_W    = MAX_SET_BITS > 0 ? MAX_SET_BITS : 1;
  localparam int WAY_W    = WAYS > 1 ? $clog2(WAYS) : 1;
  localparam int RANK_W   = WAY_W;
  localparam int WCNT_W   = $clog2(WAYS + 1);
  localparam int LINE_W   = ADDR_W + RANK_W;
  localparam logic [RANK_W:0] RANK_TOP  = (RANK_W + 1)'(WAYS - 1);
  localparam logic [RANK_W:0] RANK_NONE = (RANK_W + 1)'(WAYS);

  // address split
  logic [2:0]          s_eff;
  logic [6:0]          tag_sh;
  logic [ADDR_W-1:0]   tag_d, set_full;
  logic [SET_W-1:0]    set_d;
  logic [WCNT_W-1:0]   ways_eff;

  logic [ADDR_W-1:0]   tag_q;
  logic [SET_W-1:0]    set_q;
  logic                mod_q;

  always_comb begin
    s_eff    = (int'(set_bits_i) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_i;
    tag_sh   = 7'(s_eff) + 7'(offset_bits_i);
    tag_d    = (tag_sh >= 7'd64) ? '0 : (address_i >> tag_sh);
    set_full = (address_i >> offset_bits_i) & ((64'd1 << s_eff) - 64'd1);
    set_d    = set_full[SET_W-1:0];
    if (ways_i == 3'd0) begin
      ways_eff = WCNT_W'(1);
    end else if (int'(ways_i) > WAYS) begin
      ways_eff = WCNT_W'(WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_i);
    end
  end

  assign sts_o.is_fetch = (kind_i == KIND_IFETCH);

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      tag_q <= tag_d;
      set_q <= set_d;
      mod_q <= (kind_i == KIND_MODIFY);
    end
  end

  // one ram per way holds {tag, rank}
  logic [LINE_W-1:0] way_rdata [WAYS];
  logic [LINE_W-1:0] way_wdata [WAYS];
  logic [WAYS-1:0]   way_we;

  for (genvar g = 0; g < WAYS; g++) begin : g_way
    scu_ram #(
      .WIDTH (LINE_W),
      .DEPTH (NUM_SETS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (way_we[g]),
      .waddr_i (set_q),
      .wdata_i (way_wdata[g]),
      .re_i    (cmd_i.lookup),
      .raddr_i (set_d),
      .rdata_o (way_rdata[g])
    );
  end

  logic [NUM_SETS-1:0][WAYS-1:0] valid_q;
  logic [WAYS-1:0]   set_vld, in_use;
  logic [ADDR_W-1:0] tag_rd  [WAYS];
  logic [RANK_W-1:0] rank_rd [WAYS];
  logic [RANK_W-1:0] rank_new [WAYS];
  logic              hit_found, empty_found, vic_found, evict;
  logic [WAY_W-1:0]  hit_way, empty_way, vic_way, use_way;
  logic [RANK_W-1:0] vic_rank;
  logic [RANK_W:0]   old_rank;

  assign set_vld = valid_q[set_q];

  always_comb begin
    hit_found   = 1'b0;
    hit_way     = '0;
    empty_found = 1'b0;
    empty_way   = '0;
    vic_found   = 1'b0;
    vic_way     = '0;
    vic_rank    = '0;
    for (int w = 0; w < WAYS; w++) begin
      tag_rd[w]  = way_rdata[w][LINE_W-1:RANK_W];
      rank_rd[w] = way_rdata[w][RANK_W-1:0];
      in_use[w]  = (w < int'(ways_eff));
      if (in_use[w]) begin
        if (set_vld[w]) begin
          if (!hit_found && tag_rd[w] == tag_q) begin
            hit_found = 1'b1;
            hit_way   = WAY_W'(w);
          end
          // strict compare keeps the lowest way on equal ranks
          if (!vic_found || rank_rd[w] > vic_rank) begin
            vic_found = 1'b1;
            vic_way   = WAY_W'(w);
            vic_rank  = rank_rd[w];
          end
        end else if (!empty_found) begin
          empty_found = 1'b1;
          empty_way   = WAY_W'(w);
        end
      end
    end

    if (hit_found) begin
      use_way  = hit_way;
      old_rank = {1'b0, rank_rd[hit_way]};
    end else if (empty_found) begin
      use_way  = empty_way;
      old_rank = RANK_NONE;
    end else begin
      use_way  = vic_way;
      old_rank = {1'b0, vic_rank};
    end
    evict = !hit_found && !empty_found;

    for (int w = 0; w < WAYS; w++) begin
      rank_new[w] = rank_rd[w];
      if (WAY_W'(w) == use_way) begin
        rank_new[w] = '0;
      end else if (in_use[w] && set_vld[w] && ({1'b0, rank_rd[w]} < old_rank) &&
                   ({1'b0, rank_rd[w]} < RANK_TOP)) begin
        rank_new[w] = rank_rd[w] + 1'b1;
      end
      way_we[w]    = cmd_i.commit && in_use[w];
      way_wdata[w] = {((WAY_W'(w) == use_way) && !hit_found) ? tag_q : tag_rd[w],
                      rank_new[w]};
    end
  end

  // counters double as the result totals; they only move on commit
  logic [CNT_W-1:0] hits_q, misses_q, evicts_q;
  logic [CNT_W-1:0] hits_1, hits_d;

  always_comb begin
    hits_1 = hit_found ? sat_inc(hits_q) : hits_q;
    hits_d = mod_q ? sat_inc(hits_1) : hits_1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      hits_q   <= '0;
      misses_q <= '0;
      evicts_q <= '0;
    end else if (cmd_i.commit) begin
      hits_q <= hits_d;
      if (!hit_found) begin
        misses_q <= sat_inc(misses_q);
      end
      if (evict) begin
        evicts_q <= sat_inc(evicts_q);
      end
      if (!hit_found && empty_found) begin
        valid_q[set_q][empty_way] <= 1'b1;
      end
    end
  end

  logic hit_q, evicted_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_q     <= hit_found;
      evicted_q <= evict;
    end
  end

  assign hit_o             = hit_q;
  assign evicted_o         = evicted_q;
  assign hits_total_o      = hits_q;
  assign misses_total_o    = misses_q;
  assign evictions_total_o = evicts_q;

endmodule

@@ design/set_associative_lru_cache_sim_unit.sv @@
// result: way rams and lookup regs load on acceptance, the result regs on commit
// a new access waits until the last one commits its read-then-write of the way rams
// instruction fetches are accepted in the idle state and give no result
// reset: counters and all valid bits clear at once (no clearing pass), config to 4/4/1
// the result stays in its output register while the next item is accepted
module set_associative_lru_cache_sim_unit #(
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS         = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  scu_acc_if.sink     acc_i,
  scu_res_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import scu_pkg::*;

  localparam logic [1:0] REG_SET_BITS    = 2'd0;
  localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS        = 2'd2;

  logic [2:0] set_bits_q;
  logic [5:0] offset_bits_q;
  logic [2:0] ways_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q    <= SET_BITS_RST;
      offset_bits_q <= OFFSET_BITS_RST;
      ways_q        <= WAYS_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SET_BITS:    set_bits_q    <= pwdata[2:0];
        REG_OFFSET_BITS: offset_bits_q <= pwdata[5:0];
        REG_WAYS:        ways_q        <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SET_BITS:    prdata = 32'(set_bits_q);
      REG_OFFSET_BITS: prdata = 32'(offset_bits_q);
      REG_WAYS:        prdata = 32'(ways_q);
      default:         prdata = '0;
    endcase
  end

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  scu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (acc_i.valid),
    .in_ready_o  (acc_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  scu_dpath #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .WAYS         (WAYS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .kind_i            (acc_i.kind),
    .address_i         (acc_i.address),
    .set_bits_i        (set_bits_q),
    .offset_bits_i     (offset_bits_q),
    .ways_i            (ways_q),
    .hit_o             (res_o.hit),
    .evicted_o         (res_o.evicted),
    .hits_total_o      (res_o.hits_total),
    .misses_total_o    (res_o.misses_total),
    .evictions_total_o (res_o.evictions_total)
  );

endmodule

@@ design/scu_chk.sv @@
// port-level checks of the cache simulator unit, bound to the top level
// depends on scu_pkg and set_associative_lru_cache_sim_unit_defines.svh
`include "set_associative_lru_cache_sim_unit_defines.svh"

module scu_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [1:0]                in_kind,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_hit,
  input logic                      out_evicted,
  input logic [scu_pkg::CNT_W-1:0] out_misses,
  input logic [scu_pkg::CNT_W-1:0] out_evictions
);
  import scu_pkg::*;

  // a real access keeps the unit busy while its lookup is pending
  `SCU_ASSERT_NXT(a_busy_after_access, clk_i, rst_ni, in_valid && in_ready && in_kind != KIND_IFETCH, !in_ready)

  // a stalled result holds
  `SCU_ASSERT_NXT(a_result_holds, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_hit) && $stable(out_misses))

  // a hit never evicts
  `SCU_ASSERT_IMP(a_hit_no_evict, clk_i, rst_ni, out_valid, !(out_hit && out_evicted))

  // a miss is always counted
  `SCU_ASSERT_IMP(a_miss_counted, clk_i, rst_ni, out_valid && !out_hit, out_misses != '0)

  // an eviction is always counted
  `SCU_ASSERT_IMP(a_evict_counted, clk_i, rst_ni, out_valid && out_evicted, out_evictions != '0)

endmodule

bind set_associative_lru_cache_sim_unit scu_chk u_scu_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (acc_i.valid),
  .in_ready      (acc_i.ready),
  .in_kind       (acc_i.kind),
  .out_valid     (res_o.valid),
  .out_ready     (res_o.ready),
  .out_hit       (res_o.hit),
  .out_evicted   (res_o.evicted),
  .out_misses    (res_o.misses_total),
  .out_evictions (res_o.evictions_total)
);
